### hw/rtl/icmp_rtt_pkg.sv
// shared types, constants and helpers for the icmp echo round-trip statistics block
// no dependencies; every other file in hw/rtl imports this package
package icmp_rtt_pkg;

	// default packet length limit, bytes past it are dropped
	localparam int MAX_PACKET_BYTES_DEF = 4096;

	// number of captured message bytes per candidate offset
	localparam int NSLOT = 18;
	// slot holding absolute byte 9 (protocol) in the offset-zero view
	localparam int PROTO_SLOT = 7;

	// saturated length, enough to compare with header length plus 8
	localparam int LEN_W   = 7;
	localparam int LEN_SAT = 127;

	// results held or in flight before input is stalled
	localparam int RES_DEPTH = 16;

	// time arithmetic constants
	localparam logic [31:0] USEC_PER_SEC  = 32'd1000000;
	localparam logic [31:0] USEC_PER_MSEC = 32'd1000;
	localparam logic [31:0] MS_PER_SEC    = 32'd1000;
	localparam logic [31:0] MIN_TRIP_INIT = 32'd999999999;

	// floor(2^41 / 1000): quotient estimate is exact or one low
	localparam logic [31:0] RECIP_1000  = 32'd2199023255;
	localparam int          RECIP_SHIFT = 41;
	localparam int          Q_W         = 64 - RECIP_SHIFT;

	// icmp message types
	localparam logic [7:0] TYPE_ECHOREPLY = 8'd0;
	localparam logic [7:0] TYPE_UNREACH   = 8'd3;
	localparam logic [7:0] TYPE_SRCQUENCH = 8'd4;
	localparam logic [7:0] TYPE_REDIRECT  = 8'd5;
	localparam logic [7:0] TYPE_TIMXCEED  = 8'd11;

	// configuration register indexes
	localparam logic [1:0] REG_ECHO_IDENT    = 2'd0;
	localparam logic [1:0] REG_TIMING_ENABLE = 2'd1;
	localparam logic [1:0] REG_TARGET_ADDR   = 2'd2;

	// result classification
	typedef enum logic [2:0] {
		ST_SHORT     = 3'd0,
		ST_OUR       = 3'd1,
		ST_FOREIGN   = 3'd2,
		ST_ERR_TGT   = 3'd3,
		ST_ERR_OTHER = 3'd4,
		ST_OTHER     = 3'd5
	} status_t;

	typedef logic [NSLOT-1:0][7:0] slots_t;

	// fields of the icmp message at one candidate offset
	typedef struct packed {
		logic [7:0]  typ;
		logic [7:0]  code;
		logic [15:0] ident;
		logic [15:0] seq;
		logic [31:0] tsec;
		logic [31:0] tusec;
		logic [31:0] inner;
	} view_t;

	// packet end: saturated length and receive time
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [31:0]      sec;
		logic [19:0]      usec;
	} pkt_end_t;

	// classification carried down the trip pipeline
	typedef struct packed {
		status_t     status;
		logic [7:0]  typ;
		logic [7:0]  code;
		logic [15:0] seq;
		logic        timed;
		logic        our;
	} cls_t;

	// one result item
	typedef struct packed {
		status_t     status;
		logic [7:0]  typ;
		logic [7:0]  code;
		logic [15:0] seq;
		logic        trip_valid;
		logic [31:0] trip;
		logic [31:0] rmin;
		logic [31:0] rmax;
		logic [31:0] rsum;
		logic [31:0] count;
	} res_t;

	// message-relative offset of capture slot k
	function automatic logic [4:0] slot_rel(input int k);
		if (k < 2) begin
			return 5'(k);
		end else if (k < 14) begin
			return 5'(k + 2);
		end else begin
			return 5'(k + 10);
		end
	endfunction

	// big-endian field view of one slot set
	function automatic view_t slot_view(input slots_t b);
		view_t v;
		v.typ   = b[0];
		v.code  = b[1];
		v.ident = {b[2], b[3]};
		v.seq   = {b[4], b[5]};
		v.tsec  = {b[6], b[7], b[8], b[9]};
		v.tusec = {b[10], b[11], b[12], b[13]};
		v.inner = {b[14], b[15], b[16], b[17]};
		return v;
	endfunction

endpackage

### hw/rtl/icmp_echo_reply_rtt_stats.sv
// top level of the icmp echo round-trip statistics block
// depends on icmp_rtt_pkg, icmp_rtt_capture, icmp_rtt_classify, icmp_rtt_trip,
// icmp_rtt_stats and icmp_rtt_fifo
//
//  channel  handshake             payload
//  in       in_valid / in_stall   pkt_byte, last_byte, now_sec, now_usec
//  out      out_valid / out_stall status, msg_type, msg_code, seq_number, trip_valid,
//                                 trip_ms, rtt_min, rtt_max, rtt_sum, reply_count
//  cfg      cfg_write             cfg_index, cfg_data (no read-back)
//
// one packet byte is taken per cycle while in_stall is low; a result passes the
// capture and classification registers and the trip arithmetic pipeline (borrow,
// magnitude, reciprocal multiply, correction, sign and sum), then the statistics
// update goes with it into a 16-entry queue; in_stall rises only while 16 packet
// results are queued or in flight.
// arst_n resets the byte counter, configuration, statistics and queue; no clearing pass.
module icmp_echo_reply_rtt_stats #(
	parameter int MAX_PACKET_BYTES = icmp_rtt_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         pkt_byte,
	input  logic               last_byte,
	input  logic [31:0]        now_sec,
	input  logic [19:0]        now_usec,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [7:0]         msg_type,
	output logic [7:0]         msg_code,
	output logic [15:0]        seq_number,
	output logic               trip_valid,
	output logic signed [31:0] trip_ms,
	output logic signed [31:0] rtt_min,
	output logic signed [31:0] rtt_max,
	output logic signed [31:0] rtt_sum,
	output logic [31:0]        reply_count,
	// configuration
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import icmp_rtt_pkg::*;

	localparam int CRW = $clog2(RES_DEPTH + 1);

	logic        in_xfer;
	logic        out_xfer;
	logic [CRW-1:0] credit_q;

	logic [15:0] echo_ident_q;
	logic        timing_enable_q;
	logic [31:0] target_addr_q;

	logic        done_s1, done_s2, done_s7;
	pkt_end_t    pend_s1;
	slots_t      cap0_q, caph_q;
	cls_t        cls_s2, cls_s7;
	logic [31:0] du_s2, ds_s2, trip_s7;
	logic        push;
	res_t        res;
	res_t        head;

	// transfers and result credit
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign in_stall = credit_q == CRW'(RES_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if ((in_xfer && last_byte) && !out_xfer) begin
			credit_q <= credit_q + 1'b1;
		end else if (out_xfer && !(in_xfer && last_byte)) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_ident_q    <= 16'd0;
			timing_enable_q <= 1'b1;
			target_addr_q   <= 32'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ECHO_IDENT:    echo_ident_q    <= cfg_data[15:0];
				REG_TIMING_ENABLE: timing_enable_q <= cfg_data[0];
				REG_TARGET_ADDR:   target_addr_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	icmp_rtt_capture #(
		.MAX_BYTES (MAX_PACKET_BYTES)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_xfer),
		.pkt_byte  (pkt_byte),
		.last_byte (last_byte),
		.now_sec   (now_sec),
		.now_usec  (now_usec),
		.done_s1   (done_s1),
		.pend_s1   (pend_s1),
		.cap0_q    (cap0_q),
		.caph_q    (caph_q)
	);

	icmp_rtt_classify u_classify (
		.clk           (clk),
		.arst_n        (arst_n),
		.done_s1       (done_s1),
		.pend_s1       (pend_s1),
		.cap0_q        (cap0_q),
		.caph_q        (caph_q),
		.echo_ident    (echo_ident_q),
		.timing_enable (timing_enable_q),
		.target_addr   (target_addr_q),
		.done_s2       (done_s2),
		.cls_s2        (cls_s2),
		.du_s2         (du_s2),
		.ds_s2         (ds_s2)
	);

	icmp_rtt_trip u_trip (
		.clk     (clk),
		.arst_n  (arst_n),
		.done_s2 (done_s2),
		.cls_s2  (cls_s2),
		.du_s2   (du_s2),
		.ds_s2   (ds_s2),
		.done_s7 (done_s7),
		.cls_s7  (cls_s7),
		.trip_s7 (trip_s7)
	);

	icmp_rtt_stats u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.done_s7 (done_s7),
		.cls_s7  (cls_s7),
		.trip_s7 (trip_s7),
		.push    (push),
		.res     (res)
	);

	icmp_rtt_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (res),
		.pop    (out_xfer),
		.rvalid (out_valid),
		.rdata  (head)
	);

	// output fields
	assign status      = head.status;
	assign msg_type    = head.typ;
	assign msg_code    = head.code;
	assign seq_number  = head.seq;
	assign trip_valid  = head.trip_valid;
	assign trip_ms     = $signed(head.trip);
	assign rtt_min     = $signed(head.rmin);
	assign rtt_max     = $signed(head.rmax);
	assign rtt_sum     = $signed(head.rsum);
	assign reply_count = head.count;

	// credit covers every queued result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> credit_q != '0)
		else $error("result present without credit");

	assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CRW'(RES_DEPTH))
		else $error("result credit above queue depth");

endmodule

### hw/rtl/icmp_rtt_capture.sv
// byte counter and field capture for both candidate message offsets
// depends on icmp_rtt_pkg
module icmp_rtt_capture #(
	parameter int MAX_BYTES = icmp_rtt_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [7:0]              pkt_byte,
	input  logic                    last_byte,
	input  logic [31:0]             now_sec,
	input  logic [19:0]             now_usec,
	output logic                    done_s1,
	output icmp_rtt_pkg::pkt_end_t  pend_s1,
	output icmp_rtt_pkg::slots_t    cap0_q,
	output icmp_rtt_pkg::slots_t    caph_q
);
	import icmp_rtt_pkg::*;

	localparam int CW = $clog2(MAX_BYTES + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_inc;
	logic [5:0]    hlen_q;
	logic          room;
	logic          first;
	logic [NSLOT-1:0] hit0;
	logic [NSLOT-1:0] hith;
	slots_t        cap0_d;
	slots_t        caph_d;

	// byte position and saturation
	assign room      = count_q < CW'(MAX_BYTES);
	assign first     = count_q == '0;
	assign count_inc = room ? count_q + 1'b1 : count_q;

	// slot hits: offset zero and offset header length
	always_comb begin
		for (int k = 0; k < NSLOT; k++) begin
			hit0[k] = room && (count_q == CW'(slot_rel(k)));
			hith[k] = room && !first &&
				(count_q == CW'(7'({1'b0, hlen_q}) + 7'(slot_rel(k))));
		end
	end

	// slots clear on the first byte of a packet, so unseen bytes read as zero
	always_comb begin
		for (int k = 0; k < NSLOT; k++) begin
			cap0_d[k] = hit0[k] ? pkt_byte : (first ? 8'd0 : cap0_q[k]);
			caph_d[k] = hith[k] ? pkt_byte : (first ? 8'd0 : caph_q[k]);
		end
	end

	// packet counter and end marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept && last_byte;
			if (accept) begin
				count_q <= last_byte ? '0 : count_inc;
			end
		end
	end

	// capture payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cap0_q <= cap0_d;
			caph_q <= caph_d;
			if (first) begin
				hlen_q <= {pkt_byte[3:0], 2'b00};
			end
			if (last_byte) begin
				pend_s1.len  <= (count_inc > CW'(LEN_SAT)) ? LEN_W'(LEN_SAT)
					: LEN_W'(count_inc);
				pend_s1.sec  <= now_sec;
				pend_s1.usec <= now_usec;
			end
		end
	end

endmodule

### hw/rtl/icmp_rtt_classify.sv
// packet classification and raw time differences, one register stage
// depends on icmp_rtt_pkg
module icmp_rtt_classify (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    done_s1,
	input  icmp_rtt_pkg::pkt_end_t  pend_s1,
	input  icmp_rtt_pkg::slots_t    cap0_q,
	input  icmp_rtt_pkg::slots_t    caph_q,
	input  logic [15:0]             echo_ident,
	input  logic                    timing_enable,
	input  logic [31:0]             target_addr,
	output logic                    done_s2,
	output icmp_rtt_pkg::cls_t      cls_s2,
	output logic [31:0]             du_s2,
	output logic [31:0]             ds_s2
);
	import icmp_rtt_pkg::*;

	view_t      v0;
	view_t      vh;
	view_t      v;
	logic [5:0] hlen;
	logic       off0;
	logic       short_pkt;
	cls_t       cls;

	// pick the message offset
	assign v0        = slot_view(cap0_q);
	assign vh        = slot_view(caph_q);
	assign hlen      = {cap0_q[0][3:0], 2'b00};
	assign off0      = (cap0_q[PROTO_SLOT] == 8'd0) || (hlen == 6'd0);
	assign v         = off0 ? v0 : vh;
	assign short_pkt = pend_s1.len < (LEN_W'(hlen) + LEN_W'(8));

	// type decode
	always_comb begin
		cls = '{status: ST_SHORT, typ: 8'd0, code: 8'd0, seq: 16'd0,
			timed: 1'b0, our: 1'b0};
		if (!short_pkt) begin
			cls.typ  = v.typ;
			cls.code = v.code;
			case (v.typ)
				TYPE_UNREACH, TYPE_SRCQUENCH, TYPE_REDIRECT, TYPE_TIMXCEED: begin
					cls.status = (v.inner == target_addr) ? ST_ERR_TGT : ST_ERR_OTHER;
				end
				TYPE_ECHOREPLY: begin
					cls.seq = v.seq;
					if (v.ident == echo_ident) begin
						cls.status = ST_OUR;
						cls.our    = 1'b1;
						cls.timed  = timing_enable;
					end else begin
						cls.status = ST_FOREIGN;
					end
				end
				default: begin
					cls.status = ST_OTHER;
				end
			endcase
		end
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= done_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			cls_s2 <= cls;
			du_s2  <= {12'd0, pend_s1.usec} - v.tusec;
			ds_s2  <= pend_s1.sec - v.tsec;
		end
	end

endmodule

### hw/rtl/icmp_rtt_trip.sv
// round-trip milliseconds: borrow, magnitude, reciprocal divide by 1000, sign, sum
// depends on icmp_rtt_pkg
module icmp_rtt_trip (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                done_s2,
	input  icmp_rtt_pkg::cls_t  cls_s2,
	input  logic [31:0]         du_s2,
	input  logic [31:0]         ds_s2,
	output logic                done_s7,
	output icmp_rtt_pkg::cls_t  cls_s7,
	output logic [31:0]         trip_s7
);
	import icmp_rtt_pkg::*;

	logic           done_s3, done_s4, done_s5, done_s6;
	cls_t           cls_s3, cls_s4, cls_s5, cls_s6;
	logic [31:0]    du_s3, ds_s3;
	logic           neg_s4, neg_s5, neg_s6;
	logic [31:0]    mag_s4, mag_s5;
	logic [31:0]    dsk_s4, dsk_s5, dsk_s6;
	logic [Q_W-1:0] q0_s5, q_s6;
	logic [63:0]    prod;
	logic [31:0]    q0k;
	logic [31:0]    rem;
	logic [31:0]    qx;
	logic [31:0]    qs;

	// reciprocal product and remainder correction
	assign prod = {32'd0, mag_s4} * {32'd0, RECIP_1000};
	assign q0k  = 32'(q0_s5) * USEC_PER_MSEC;
	assign rem  = mag_s5 - q0k;
	assign qx   = 32'(q_s6);
	assign qs   = neg_s6 ? (~qx + 32'd1) : qx;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
			done_s4 <= 1'b0;
			done_s5 <= 1'b0;
			done_s6 <= 1'b0;
			done_s7 <= 1'b0;
		end else begin
			done_s3 <= done_s2;
			done_s4 <= done_s3;
			done_s5 <= done_s4;
			done_s6 <= done_s5;
			done_s7 <= done_s6;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		// borrow a second when the microsecond difference is negative
		cls_s3 <= cls_s2;
		du_s3  <= du_s2[31] ? du_s2 + USEC_PER_SEC : du_s2;
		ds_s3  <= ds_s2 - {31'd0, du_s2[31]};
		// sign and magnitude, seconds scaled to milliseconds
		cls_s4 <= cls_s3;
		neg_s4 <= du_s3[31];
		mag_s4 <= du_s3[31] ? (~du_s3 + 32'd1) : du_s3;
		dsk_s4 <= ds_s3 * MS_PER_SEC;
		// quotient estimate
		cls_s5 <= cls_s4;
		neg_s5 <= neg_s4;
		mag_s5 <= mag_s4;
		dsk_s5 <= dsk_s4;
		q0_s5  <= prod[63:RECIP_SHIFT];
		// estimate is at most one low
		cls_s6 <= cls_s5;
		neg_s6 <= neg_s5;
		dsk_s6 <= dsk_s5;
		q_s6   <= (rem >= USEC_PER_MSEC) ? q0_s5 + 1'b1 : q0_s5;
		// truncate toward zero and add
		cls_s7  <= cls_s6;
		trip_s7 <= cls_s6.timed ? dsk_s6 + qs : 32'd0;
	end

	// reciprocal estimate leaves less than two divisors of remainder
	assert property (@(posedge clk) disable iff (!arst_n)
		done_s5 |-> rem < (USEC_PER_MSEC + USEC_PER_MSEC))
		else $error("divide-by-1000 estimate out of range");

endmodule

### hw/rtl/icmp_rtt_stats.sv
// running minimum, maximum, wrapping sum and reply count, result assembly
// depends on icmp_rtt_pkg
module icmp_rtt_stats (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                done_s7,
	input  icmp_rtt_pkg::cls_t  cls_s7,
	input  logic [31:0]         trip_s7,
	output logic                push,
	output icmp_rtt_pkg::res_t  res
);
	import icmp_rtt_pkg::*;

	logic [31:0] min_q, max_q, sum_q, cnt_q;
	logic [31:0] min_d, max_d, sum_d, cnt_d;
	logic        upd;

	// statistics after this packet
	assign upd   = done_s7 && cls_s7.timed;
	assign min_d = (upd && ($signed(trip_s7) < $signed(min_q))) ? trip_s7 : min_q;
	assign max_d = (upd && ($signed(trip_s7) > $signed(max_q))) ? trip_s7 : max_q;
	assign sum_d = upd ? sum_q + trip_s7 : sum_q;
	assign cnt_d = (done_s7 && cls_s7.our) ? cnt_q + 32'd1 : cnt_q;

	// result item
	assign push = done_s7;
	assign res  = '{status: cls_s7.status, typ: cls_s7.typ, code: cls_s7.code,
		seq: cls_s7.seq, trip_valid: cls_s7.timed, trip: trip_s7,
		rmin: min_d, rmax: max_d, rsum: sum_d, count: cnt_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_TRIP_INIT;
			max_q <= 32'd0;
			sum_q <= 32'd0;
			cnt_q <= 32'd0;
		end else if (done_s7) begin
			min_q <= min_d;
			max_q <= max_d;
			sum_q <= sum_d;
			cnt_q <= cnt_d;
		end
	end

	// a fresh trip lies within the updated bounds
	assert property (@(posedge clk) disable iff (!arst_n)
		push && res.trip_valid |->
			($signed(min_d) <= $signed(trip_s7)) && ($signed(trip_s7) <= $signed(max_d)))
		else $error("trip outside running min/max");

endmodule

### hw/rtl/icmp_rtt_fifo.sv
// result queue between the trip pipeline and the output channel
// depends on icmp_rtt_pkg
module icmp_rtt_fifo #(
	parameter int DEPTH = icmp_rtt_pkg::RES_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  icmp_rtt_pkg::res_t  wdata,
	input  logic                pop,
	output logic                rvalid,
	output icmp_rtt_pkg::res_t  rdata
);
	import icmp_rtt_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;

	assign rvalid = cnt_q != '0;
	assign rdata  = mem_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// credit scheme upstream keeps the queue from overflowing
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != NW'(DEPTH)) || pop)
		else $error("result queue overflow");

endmodule

### test/testbench.sv
// self-checking testbench for the icmp echo round-trip statistics block
// depends on icmp_rtt_pkg and icmp_echo_reply_rtt_stats; packets are fed byte by byte,
// each result is checked against a packet classifier and trip-time tracker kept here
module testbench;
	import icmp_rtt_pkg::*;

	localparam int CAP_DEPTH    = 128;
	localparam int MAX_BYTES    = 4096;
	localparam int CYCLE_LIMIT  = 40000;
	localparam int DRAIN_CYCLES = 20;
	localparam int N_DIRECTED   = 20;
	localparam int PHASE_BYTES  = 140;
	localparam int PHASE_PKTS   = 3;
	localparam int MAX_REPORTS  = 10;

	// one packet to send: header and message fields, receive time, optional known result
	typedef struct {
		int          plen;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [7:0]  typ;
		logic [7:0]  code;
		logic [15:0] ident;
		logic [15:0] seq;
		logic [31:0] tsec;
		logic [31:0] tusec;
		logic [31:0] inner;
		logic [31:0] nsec;
		logic [19:0] nusec;
		bit          typed;
		status_t     t_status;
		logic        t_valid;
		logic [31:0] t_trip;
	} pkt_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         pkt_byte = 8'd0;
	logic               last_byte = 1'b0;
	logic [31:0]        now_sec = 32'd0;
	logic [19:0]        now_usec = 20'd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         status;
	logic [7:0]         msg_type;
	logic [7:0]         msg_code;
	logic [15:0]        seq_number;
	logic               trip_valid;
	logic signed [31:0] trip_ms;
	logic signed [31:0] rtt_min;
	logic signed [31:0] rtt_max;
	logic signed [31:0] rtt_sum;
	logic [31:0]        reply_count;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = REG_ECHO_IDENT;
	logic [31:0]        cfg_data = 32'd0;

	// local copy of the block state
	logic [7:0]  cap_mem [CAP_DEPTH];
	int          byte_total = 0;
	logic [15:0] own_ident = 16'd0;
	logic        own_timed = 1'b1;
	logic [31:0] own_target = 32'd0;
	logic [31:0] min_rtt = MIN_TRIP_INIT;
	logic [31:0] max_rtt = 32'd0;
	logic [31:0] sum_rtt = 32'd0;
	logic [31:0] reply_total = 32'd0;
	res_t        pending_results [$];

	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;
	int          byte_sent = 0;
	int          pkt_sent = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	pkt_row_t    directed_rows [N_DIRECTED];

	icmp_echo_reply_rtt_stats dut (.*);

	always #1 clk = ~clk;

	// captured byte, zero past the packet or the capture depth
	function automatic logic [7:0] cap_at(input int idx, input int len);
		if (idx >= len || idx >= CAP_DEPTH) begin
			return 8'd0;
		end
		return cap_mem[idx];
	endfunction

	function automatic logic [15:0] cap16(input int idx, input int len);
		return {cap_at(idx, len), cap_at(idx + 1, len)};
	endfunction

	function automatic logic [31:0] cap32(input int idx, input int len);
		return {cap16(idx, len), cap16(idx + 2, len)};
	endfunction

	// classify a finished packet, update the statistics and queue the result
	task automatic classify_packet(input int len, input logic [31:0] nsec,
		input logic [19:0] nusec);
		res_t               r;
		int                 hlen;
		int                 off;
		logic [31:0]        du;
		logic [31:0]        ds;
		logic [31:0]        trip;
		logic signed [31:0] q;
		r = '0;
		r.status = ST_SHORT;
		hlen = int'(cap_at(0, len) & 8'h0F) * 4;
		if (len >= hlen + 8) begin
			off = (cap_at(9, len) == 8'd0) ? 0 : hlen;
			r.typ = cap_at(off, len);
			r.code = cap_at(off + 1, len);
			if (r.typ == TYPE_UNREACH || r.typ == TYPE_SRCQUENCH ||
				r.typ == TYPE_REDIRECT || r.typ == TYPE_TIMXCEED) begin
				r.status = (cap32(off + 24, len) == own_target) ? ST_ERR_TGT : ST_ERR_OTHER;
			end else if (r.typ == TYPE_ECHOREPLY) begin
				r.seq = cap16(off + 6, len);
				if (cap16(off + 4, len) != own_ident) begin
					r.status = ST_FOREIGN;
				end else begin
					r.status = ST_OUR;
					if (own_timed) begin
						// microsecond difference borrows one second when negative
						du = {12'd0, nusec} - cap32(off + 12, len);
						ds = nsec;
						if (du[31]) begin
							ds = ds - 32'd1;
							du = du + USEC_PER_SEC;
						end
						ds = ds - cap32(off + 8, len);
						q = $signed(du) / 32'sd1000;
						trip = ds * MS_PER_SEC + q;
						r.trip_valid = 1'b1;
						r.trip = trip;
						sum_rtt = sum_rtt + trip;
						if ($signed(trip) < $signed(min_rtt)) begin
							min_rtt = trip;
						end
						if ($signed(trip) > $signed(max_rtt)) begin
							max_rtt = trip;
						end
					end
					reply_total = reply_total + 32'd1;
				end
			end else begin
				r.status = ST_OTHER;
			end
		end
		r.rmin = min_rtt;
		r.rmax = max_rtt;
		r.rsum = sum_rtt;
		r.count = reply_total;
		pending_results.push_back(r);
	endtask

	// one accepted byte: store it, saturate the length, finish the packet on the marker
	task automatic take_byte(input logic [7:0] b, input logic last, input logic [31:0] nsec,
		input logic [19:0] nusec);
		if (byte_total < MAX_BYTES) begin
			if (byte_total < CAP_DEPTH) begin
				cap_mem[byte_total] = b;
			end
			byte_total++;
		end
		if (last) begin
			classify_packet(byte_total, nsec, nusec);
			byte_total = 0;
		end
	endtask

	// drive one byte from a falling edge and hold it until its transfer
	task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] nsec,
		input logic [19:0] nusec);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		pkt_byte = b;
		last_byte = last;
		now_sec = nsec;
		now_usec = nusec;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		take_byte(b, last, nsec, nusec);
		@(negedge clk);
	endtask

	// big-endian field into the packet, cut at its end
	function automatic void place(ref logic [7:0] pkt [], input int idx,
		input logic [31:0] val, input int nbytes);
		for (int k = 0; k < nbytes; k++) begin
			if (idx + k < pkt.size()) begin
				pkt[idx + k] = val[8 * (nbytes - 1 - k) +: 8];
			end
		end
	endfunction

	// build the packet bytes around random filler and send them
	task automatic send_packet(input pkt_row_t row);
		logic [7:0] body [];
		int         off;
		logic [31:0] usec_noise;
		body = new[row.plen];
		foreach (body[i]) begin
			body[i] = 8'($urandom);
		end
		off = (row.proto == 8'd0) ? 0 : 4 * row.ihl;
		place(body, 0, {body[0][7:4], row.ihl}, 1);
		place(body, off, row.typ, 1);
		place(body, off + 1, row.code, 1);
		place(body, off + 4, row.ident, 2);
		place(body, off + 6, row.seq, 2);
		place(body, off + 8, row.tsec, 4);
		place(body, off + 12, row.tusec, 4);
		if (row.typ == TYPE_UNREACH || row.typ == TYPE_SRCQUENCH ||
			row.typ == TYPE_REDIRECT || row.typ == TYPE_TIMXCEED) begin
			place(body, off + 24, row.inner, 4);
		end
		// protocol byte last so that it decides the message offset
		place(body, 9, row.proto, 1);
		for (int i = 0; i < row.plen; i++) begin
			if (i == row.plen - 1) begin
				send_byte(body[i], 1'b1, row.nsec, row.nusec);
			end else begin
				usec_noise = $urandom_range(999999);
				send_byte(body[i], 1'b0, $urandom, usec_noise[19:0]);
			end
		end
		if (row.typed) begin
			pending_results[$].status = row.t_status;
			pending_results[$].trip_valid = row.t_valid;
			pending_results[$].trip = row.t_trip;
		end
		byte_sent += row.plen;
		pkt_sent++;
	endtask

	// mostly well-formed replies and error reports, some unknown types and noise
	function automatic pkt_row_t make_random_row();
		pkt_row_t r;
		int       kind;
		int       need;
		int       off;
		kind = $urandom_range(99);
		r.ihl = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
		r.proto = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		r.code = 8'($urandom);
		r.ident = 16'($urandom);
		r.seq = 16'($urandom);
		r.tsec = $urandom;
		r.tusec = $urandom;
		r.inner = $urandom;
		r.nsec = $urandom;
		r.nusec = 20'($urandom_range(999999));
		r.typed = 1'b0;
		r.t_status = ST_SHORT;
		r.t_valid = 1'b0;
		r.t_trip = 32'd0;
		off = (r.proto == 8'd0) ? 0 : 4 * r.ihl;
		if (kind < 45) begin
			r.typ = TYPE_ECHOREPLY;
			need = off + 16;
			if ($urandom_range(99) < 85) begin
				r.ident = own_ident;
			end
			// sane timestamps most of the time, garbage otherwise
			if ($urandom_range(7) != 0) begin
				r.tusec = $urandom_range(999999);
				r.nsec = r.tsec + $urandom_range(3);
			end
		end else if (kind < 65) begin
			case ($urandom_range(3))
				0: r.typ = TYPE_UNREACH;
				1: r.typ = TYPE_SRCQUENCH;
				2: r.typ = TYPE_REDIRECT;
				default: r.typ = TYPE_TIMXCEED;
			endcase
			need = off + 28;
			if ($urandom_range(99) < 60) begin
				r.inner = own_target;
			end
		end else if (kind < 80) begin
			r.typ = 8'($urandom);
			need = off + 8;
		end else begin
			r.typ = 8'($urandom);
			need = $urandom_range(1, 40);
		end
		r.plen = need + $urandom_range(12);
		if ($urandom_range(9) == 0) begin
			r.plen = $urandom_range(1, need);
		end else if ($urandom_range(39) == 0) begin
			r.plen = $urandom_range(100, 180);
		end
		return r;
	endfunction

	// register write while the block is idle
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			REG_ECHO_IDENT: own_ident = val[15:0];
			REG_TIMING_ENABLE: own_timed = val[0];
			REG_TARGET_ADDR: own_target = val;
			default: ;
		endcase
	endtask

	// wait for every expected result, then let the pipeline go quiet
	task automatic settle();
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// receiver stall
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < recv_stall_pct);
	end

	// result check on each output transfer
	always @(posedge clk) begin : result_check
		res_t seen;
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen.status = status_t'(status);
			seen.typ = msg_type;
			seen.code = msg_code;
			seen.seq = seq_number;
			seen.trip_valid = trip_valid;
			seen.trip = trip_ms;
			seen.rmin = rtt_min;
			seen.rmax = rtt_max;
			seen.rsum = rtt_sum;
			seen.count = reply_count;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$display("unexpected result: status %0d type %0d seq %0d trip %0d",
						status, msg_type, seq_number, trip_ms);
				end
			end else begin
				want = pending_results.pop_front();
				if (seen.status != want.status || seen.typ != want.typ ||
					seen.code != want.code || seen.seq != want.seq ||
					seen.trip_valid != want.trip_valid || seen.trip != want.trip ||
					seen.rmin != want.rmin || seen.rmax != want.rmax ||
					seen.rsum != want.rsum || seen.count != want.count) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("result mismatch (expected/actual): status %0d/%0d type %0d/%0d",
							want.status, seen.status, want.typ, seen.typ);
						$display("  code %0d/%0d seq %0d/%0d trip_valid %0d/%0d trip %0d/%0d",
							want.code, seen.code, want.seq, seen.seq,
							want.trip_valid, seen.trip_valid,
							$signed(want.trip), $signed(seen.trip));
						$display("  min %0d/%0d max %0d/%0d sum %0d/%0d count %0d/%0d",
							$signed(want.rmin), $signed(seen.rmin),
							$signed(want.rmax), $signed(seen.rmax),
							$signed(want.rsum), $signed(seen.rsum), want.count, seen.count);
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int phase_bytes;
		int phase_pkts;
		// plen, ihl, proto, type, code, ident, seq, tsec, tusec, inner, now sec, now usec,
		// known result flag, status, trip valid, trip
		directed_rows = '{
			// one-byte packet and one byte short of header plus 8
			'{1, 4'd0, 8'd1, TYPE_ECHOREPLY, 8'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
				32'd0, 20'd0, 1'b1, ST_SHORT, 1'b0, 32'd0},
			'{27, 4'd5, 8'd1, TYPE_ECHOREPLY, 8'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
				32'd0, 20'd0, 1'b1, ST_SHORT, 1'b0, 32'd0},
			// our replies: plain, with borrow, wrapping to minus one
			'{36, 4'd5, 8'd1, TYPE_ECHOREPLY, 8'd0, 16'd0, 16'hFFFF, 32'd100, 32'd0, 32'd0,
				32'd100, 20'd999999, 1'b1, ST_OUR, 1'b1, 32'd999},
			'{36, 4'd5, 8'd1, TYPE_ECHOREPLY, 8'd0, 16'd0, 16'd0, 32'd100, 32'd999999, 32'd0,
				32'd101, 20'd0, 1'b1, ST_OUR, 1'b1, 32'd0},
			'{36, 4'd5, 8'd1, TYPE_ECHOREPLY, 8'd0, 16'd0, 16'd1, 32'd0, 32'd0, 32'd0,
				32'hFFFFFFFF, 20'd999999, 1'b1, ST_OUR, 1'b1, 32'hFFFFFFFF},
			// garbage microseconds and the largest positive second difference
			'{36, 4'd5, 8'd1, TYPE_ECHOREPLY, 8'd0, 16'd0, 16'd2, 32'd0, 32'h80000000, 32'd0,
				32'd0, 20'd0, 1'b0, ST_SHORT, 1'b0, 32'd0},
			'{36, 4'd5, 8'd1, TYPE_ECHOREPLY, 8'd0, 16'd0, 16'd3, 32'd0, 32'd0, 32'd0,
				32'h7FFFFFFF, 20'd999999, 1'b0, ST_SHORT, 1'b0, 32'd0},
			// reply to somebody else
			'{40, 4'd5, 8'd1, TYPE_ECHOREPLY, 8'hFF, 16'h1234, 16'h5678, 32'd0, 32'd0, 32'd0,
				32'd0, 20'd0, 1'b1, ST_FOREIGN, 1'b0, 32'd0},
			// error reports about the target, about another host, and cut short
			'{48, 4'd5, 8'd1, TYPE_UNREACH, 8'd1, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
				32'd0, 20'd0, 1'b1, ST_ERR_TGT, 1'b0, 32'd0},
			'{48, 4'd5, 8'd1, TYPE_SRCQUENCH, 8'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
				32'd0, 20'd0, 1'b1, ST_ERR_TGT, 1'b0, 32'd0},
			'{48, 4'd5, 8'd1, TYPE_REDIRECT, 8'd2, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
				32'd0, 20'd0, 1'b1, ST_ERR_TGT, 1'b0, 32'd0},
			'{48, 4'd5, 8'd1, TYPE_TIMXCEED, 8'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
				32'd0, 20'd0, 1'b1, ST_ERR_TGT, 1'b0, 32'd0},
			'{48, 4'd5, 8'd1, TYPE_UNREACH, 8'd3, 16'd0, 16'd0, 32'd0, 32'd0, 32'hFFFFFFFF,
				32'd0, 20'd0, 1'b1, ST_ERR_OTHER, 1'b0, 32'd0},
			'{30, 4'd5, 8'd1, TYPE_TIMXCEED, 8'd1, 16'd0, 16'd0, 32'd0, 32'd0, 32'hFFFFFFFF,
				32'd0, 20'd0, 1'b1, ST_ERR_TGT, 1'b0, 32'd0},
			// types that are neither replies nor error reports
			'{28, 4'd5, 8'd1, 8'd8, 8'hFF, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
				32'd0, 20'd0, 1'b1, ST_OTHER, 1'b0, 32'd0},
			'{28, 4'd5, 8'd1, 8'hFF, 8'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
				32'd0, 20'd0, 1'b1, ST_OTHER, 1'b0, 32'd0},
			// zero protocol byte puts the message at offset zero
			'{24, 4'd0, 8'd0, TYPE_ECHOREPLY, 8'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
				32'd1, 20'd0, 1'b0, ST_SHORT, 1'b0, 32'd0},
			// longest header, in a packet longer than the capture depth
			'{140, 4'd15, 8'd1, TYPE_ECHOREPLY, 8'd0, 16'd0, 16'd7, 32'd5, 32'd0, 32'd0,
				32'd5, 20'd1000, 1'b1, ST_OUR, 1'b1, 32'd1},
			// borrow across two seconds
			'{36, 4'd5, 8'd1, TYPE_ECHOREPLY, 8'd0, 16'd0, 16'd9, 32'd7, 32'd500000, 32'd0,
				32'd9, 20'd250000, 1'b1, ST_OUR, 1'b1, 32'd1750},
			// error report past the capture depth
			'{130, 4'd5, 8'd1, TYPE_UNREACH, 8'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
				32'd0, 20'd0, 1'b1, ST_ERR_TGT, 1'b0, 32'd0}
		};

		// reset
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed packets at reset configuration
		send_gap_pct = 31;
		recv_stall_pct = 56;
		foreach (directed_rows[i]) begin
			send_packet(directed_rows[i]);
		end

		// random phases, each with its own configuration and idling
		for (int ph = 0; ph < 3; ph++) begin
			in_valid = 1'b0;
			settle();
			case (ph)
				0: begin
					send_gap_pct = 31;
					recv_stall_pct = 56;
					write_reg(REG_ECHO_IDENT, 32'($urandom_range(1, 65534)));
					write_reg(REG_TIMING_ENABLE, 32'd1);
					write_reg(REG_TARGET_ADDR, $urandom);
				end
				1: begin
					send_gap_pct = 56;
					recv_stall_pct = 31;
					write_reg(REG_ECHO_IDENT, 32'h0000FFFF);
					write_reg(REG_TIMING_ENABLE, 32'd0);
					write_reg(REG_TARGET_ADDR, 32'hFFFFFFFF);
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
					write_reg(REG_ECHO_IDENT, 32'd0);
					write_reg(REG_TIMING_ENABLE, 32'd1);
					write_reg(REG_TARGET_ADDR, 32'd0);
				end
			endcase
			phase_bytes = byte_sent + PHASE_BYTES;
			phase_pkts = pkt_sent + PHASE_PKTS;
			while (byte_sent < phase_bytes || pkt_sent < phase_pkts) begin
				send_packet(make_random_row());
			end
		end

		in_valid = 1'b0;
		settle();
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/icmp_rtt_pkg.sv
hw/rtl/icmp_rtt_capture.sv
hw/rtl/icmp_rtt_classify.sv
hw/rtl/icmp_rtt_trip.sv
hw/rtl/icmp_rtt_stats.sv
hw/rtl/icmp_rtt_fifo.sv
hw/rtl/icmp_echo_reply_rtt_stats.sv
test/testbench.sv
